/* rtl/stl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_pkg
// shared types and constants of the sql token lexer
// ----------------------------------------------------------------------------
package stl_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_STRFULL, M_GT, M_LT, M_BANG, M_HALT
    } t_mode;

    localparam logic [1:0] REC_BYTE = 2'd0;
    localparam logic [1:0] REC_TOKEN = 2'd1;
    localparam logic [1:0] REC_DONE = 2'd2;

    localparam logic [5:0] TK_IDENT = 6'd0;
    localparam logic [5:0] TK_STRING = 6'd1;
    localparam logic [5:0] TK_NUMBER = 6'd2;
    localparam logic [5:0] TK_STAR = 6'd3;
    localparam logic [5:0] TK_EQ = 6'd4;
    localparam logic [5:0] TK_GE = 6'd5;
    localparam logic [5:0] TK_LE = 6'd6;
    localparam logic [5:0] TK_NE = 6'd7;
    localparam logic [5:0] TK_GT = 6'd8;
    localparam logic [5:0] TK_LT = 6'd9;
    localparam logic [5:0] TK_LPAREN = 6'd10;
    localparam logic [5:0] TK_RPAREN = 6'd11;
    localparam logic [5:0] TK_COMMA = 6'd12;
    localparam logic [5:0] TK_SEMI = 6'd13;
    localparam logic [5:0] TK_KW_BASE = 6'd14;

    localparam int KW_COUNT = 27;

    // one result record
    typedef struct packed {
        logic [1:0] rec_kind;
        logic [7:0] value_byte;
        logic [5:0] token_kind;
        logic [5:0] token_length;
        logic [6:0] token_total;
        logic       run_end;
    } t_rec;

    // up to four records made by one byte
    typedef struct packed {
        logic [2:0] count;
        t_rec [3:0] recs;
    } t_burst;

    // keyword text, upper case, zero padded, first char in the top byte
    function automatic logic [63:0] kw_text(input int idx);
        logic [63:0] t;
        case (idx)
            0: t = {"SELECT", 16'h0};
            1: t = {"INSERT", 16'h0};
            2: t = {"DELETE", 16'h0};
            3: t = {"UPDATE", 16'h0};
            4: t = {"WHERE", 24'h0};
            5: t = {"FROM", 32'h0};
            6: t = {"INTO", 32'h0};
            7: t = {"VALUES", 16'h0};
            8: t = {"SET", 40'h0};
            9: t = {"AND", 40'h0};
            10: t = {"OR", 48'h0};
            11: t = {"NOT", 40'h0};
            12: t = "DISTINCT";
            13: t = {"ORDER", 24'h0};
            14: t = {"BY", 48'h0};
            15: t = {"LIMIT", 24'h0};
            16: t = {"OFFSET", 16'h0};
            17: t = {"FETCH", 24'h0};
            18: t = {"FIRST", 24'h0};
            19: t = {"NEXT", 32'h0};
            20: t = {"ROWS", 32'h0};
            21: t = {"ONLY", 32'h0};
            22: t = {"LIKE", 32'h0};
            23: t = {"IN", 48'h0};
            24: t = {"BETWEEN", 8'h0};
            25: t = {"ASC", 40'h0};
            26: t = {"DESC", 32'h0};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [3:0] kw_len(input int idx);
        logic [3:0] n;
        logic [63:0] t;
        n = 4'd0;
        t = kw_text(idx);
        for (int j = 0; j < 8; j++) begin
            if (t[63-8*j -: 8] != 8'h0) n = 4'(j + 1);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

/* rtl/stl_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_in_if / stl_out_if
// valid-ready channels of the lexer
// ----------------------------------------------------------------------------
interface stl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;
    modport source (output valid, in_byte, in_last, input ready);
    modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface stl_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] rec_kind;
    logic [7:0] value_byte;
    logic [5:0] token_kind;
    logic [5:0] token_length;
    logic [6:0] token_total;
    logic       run_end;
    modport source (output valid, rec_kind, value_byte, token_kind, token_length,
                    token_total, run_end, input ready);
    modport sink (input valid, rec_kind, value_byte, token_kind, token_length,
                  token_total, run_end, output ready);
endinterface
`default_nettype wire

/* rtl/stl_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_front
// lexer state machine: one byte per cycle while i_take is high, into a burst of up to four records
// ----------------------------------------------------------------------------
module stl_front #(
    parameter int TOKEN_BYTES = 64,
    parameter int MAX_TOKENS = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_take,
    input  wire [7:0]           i_byte,
    input  wire                 i_last,
    output stl_pkg::t_burst     o_burst
);
    localparam int LW = $clog2(TOKEN_BYTES);
    localparam int TW = $clog2(MAX_TOKENS + 1);
    localparam logic [LW-1:0] LEN_CAP = LW'(TOKEN_BYTES - 1);
    localparam logic [TW-1:0] TOK_CAP = TW'(MAX_TOKENS);

    stl_pkg::t_mode r_mode, n_mode;
    logic           r_dq, n_dq;
    logic [LW-1:0]  r_len, n_len;
    logic [TW-1:0]  r_tok, n_tok;
    logic [63:0]    r_win, n_win;
    stl_pkg::t_burst bst;

    // keyword match on the window and current length
    function automatic logic [5:0] classify(input logic [63:0] w, input logic [LW-1:0] n);
        logic [5:0]  k;
        logic        same;
        logic [63:0] t;
        k = stl_pkg::TK_IDENT;
        for (int i = 0; i < stl_pkg::KW_COUNT; i++) begin
            same = 1'b1;
            t = stl_pkg::kw_text(i);
            for (int j = 0; j < 8; j++) begin
                if (j < int'(n) && w[63-8*j -: 8] != t[63-8*j -: 8])
                    same = 1'b0;
            end
            if (same && int'(n) == int'(stl_pkg::kw_len(i)) && k == stl_pkg::TK_IDENT)
                k = 6'(int'(stl_pkg::TK_KW_BASE) + i);
        end
        return k;
    endfunction

    function automatic logic is_dig(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic logic is_alp(input logic [7:0] b);
        return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    endfunction

    always_comb begin
        logic [7:0] b, q, u;
        logic       fr;
        logic [5:0] fk;
        b = i_byte;
        q = r_dq ? 8'h22 : 8'h27;
        u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
        n_mode = r_mode; n_dq = r_dq; n_len = r_len; n_tok = r_tok; n_win = r_win;
        bst = '0;
        fr = 1'b0;
        fk = stl_pkg::TK_IDENT;
        case (r_mode)
            stl_pkg::M_IDENT: begin
                if (is_alp(b) || is_dig(b) || b == "_") fr = 1'b0;
                else begin
                    fk = classify(r_win, r_len);
                    bst.recs[bst.count[1:0]] = '{stl_pkg::REC_TOKEN, 8'd0, fk, 6'(r_len), 7'd0, 1'b0};
                    bst.count = bst.count + 3'd1;
                    n_tok = r_tok + 1'b1; n_len = '0;
                    n_mode = (n_tok >= TOK_CAP) ? stl_pkg::M_HALT : stl_pkg::M_IDLE;
                    fr = 1'b1;
                end
                if (!fr) begin
                    if (r_len < LW'(8)) n_win[63-8*r_len[2:0] -: 8] = u;
                    bst.recs[0] = '{stl_pkg::REC_BYTE, u, 6'd0, 6'd0, 7'd0, 1'b0};
                    bst.count = 3'd1;
                    n_len = r_len + 1'b1;
                    if (n_len >= LEN_CAP) begin
                        bst.recs[1] = '{stl_pkg::REC_TOKEN, 8'd0, classify(n_win, n_len),
                                        6'(n_len), 7'd0, 1'b0};
                        bst.count = 3'd2;
                        n_tok = r_tok + 1'b1; n_len = '0;
                        n_mode = (n_tok >= TOK_CAP) ? stl_pkg::M_HALT : stl_pkg::M_IDLE;
                    end
                end
            end
            stl_pkg::M_NUMBER: begin
                if (is_dig(b)) begin
                    bst.recs[0] = '{stl_pkg::REC_BYTE, b, 6'd0, 6'd0, 7'd0, 1'b0};
                    bst.count = 3'd1;
                    n_len = r_len + 1'b1;
                    if (n_len >= LEN_CAP) begin
                        bst.recs[1] = '{stl_pkg::REC_TOKEN, 8'd0, stl_pkg::TK_NUMBER,
                                        6'(n_len), 7'd0, 1'b0};
                        bst.count = 3'd2;
                        n_tok = r_tok + 1'b1; n_len = '0;
                        n_mode = (n_tok >= TOK_CAP) ? stl_pkg::M_HALT : stl_pkg::M_IDLE;
                    end
                end else begin
                    bst.recs[0] = '{stl_pkg::REC_TOKEN, 8'd0, stl_pkg::TK_NUMBER, 6'(r_len),
                                    7'd0, 1'b0};
                    bst.count = 3'd1;
                    n_tok = r_tok + 1'b1; n_len = '0;
                    n_mode = (n_tok >= TOK_CAP) ? stl_pkg::M_HALT : stl_pkg::M_IDLE;
                    fr = 1'b1;
                end
            end
            stl_pkg::M_STRING: begin
                if (b == q) begin
                    bst.recs[0] = '{stl_pkg::REC_TOKEN, 8'd0, stl_pkg::TK_STRING, 6'(r_len),
                                    7'd0, 1'b0};
                    bst.count = 3'd1;
                    n_tok = r_tok + 1'b1; n_len = '0;
                    n_mode = (n_tok >= TOK_CAP) ? stl_pkg::M_HALT : stl_pkg::M_IDLE;
                end else begin
                    bst.recs[0] = '{stl_pkg::REC_BYTE, b, 6'd0, 6'd0, 7'd0, 1'b0};
                    bst.count = 3'd1;
                    n_len = r_len + 1'b1;
                    if (n_len >= LEN_CAP) begin
                        bst.recs[1] = '{stl_pkg::REC_TOKEN, 8'd0, stl_pkg::TK_STRING,
                                        6'(n_len), 7'd0, 1'b0};
                        bst.count = 3'd2;
                        n_tok = r_tok + 1'b1; n_len = '0;
                        n_mode = (n_tok >= TOK_CAP) ? stl_pkg::M_HALT : stl_pkg::M_STRFULL;
                    end
                end
            end
            stl_pkg::M_STRFULL: begin
                n_mode = stl_pkg::M_IDLE;
                fr = (b != q);
            end
            stl_pkg::M_GT, stl_pkg::M_LT: begin
                if (b == "=" || (r_mode == stl_pkg::M_LT && b == ">")) begin
                    bst.recs[0] = '{stl_pkg::REC_BYTE, b, 6'd0, 6'd0, 7'd0, 1'b0};
                    bst.recs[1] = '{stl_pkg::REC_TOKEN, 8'd0,
                        (r_mode == stl_pkg::M_GT) ? stl_pkg::TK_GE :
                        (b == "=") ? stl_pkg::TK_LE : stl_pkg::TK_NE,
                        6'(r_len + 1'b1), 7'd0, 1'b0};
                    bst.count = 3'd2;
                    fr = 1'b0;
                end else begin
                    bst.recs[0] = '{stl_pkg::REC_TOKEN, 8'd0,
                        (r_mode == stl_pkg::M_GT) ? stl_pkg::TK_GT : stl_pkg::TK_LT,
                        6'(r_len), 7'd0, 1'b0};
                    bst.count = 3'd1;
                    fr = 1'b1;
                end
                n_tok = r_tok + 1'b1; n_len = '0;
                n_mode = (n_tok >= TOK_CAP) ? stl_pkg::M_HALT : stl_pkg::M_IDLE;
            end
            stl_pkg::M_BANG: begin
                n_mode = stl_pkg::M_IDLE;
                if (b == "=") begin
                    bst.recs[0] = '{stl_pkg::REC_BYTE, 8'h21, 6'd0, 6'd0, 7'd0, 1'b0};
                    bst.recs[1] = '{stl_pkg::REC_BYTE, b, 6'd0, 6'd0, 7'd0, 1'b0};
                    bst.recs[2] = '{stl_pkg::REC_TOKEN, 8'd0, stl_pkg::TK_NE, 6'(r_len + 2'd2),
                                    7'd0, 1'b0};
                    bst.count = 3'd3;
                    n_tok = r_tok + 1'b1; n_len = '0;
                    n_mode = (n_tok >= TOK_CAP) ? stl_pkg::M_HALT : stl_pkg::M_IDLE;
                end else fr = 1'b1;
            end
            stl_pkg::M_HALT: fr = 1'b0;
            default: begin
                n_mode = stl_pkg::M_IDLE;
                fr = 1'b1;
            end
        endcase

        // start a fresh token on this byte
        if (fr && n_mode != stl_pkg::M_HALT) begin
            n_mode = stl_pkg::M_IDLE;
            n_len = '0;
            fk = stl_pkg::TK_IDENT;
            if (b == 8'h27 || b == 8'h22) begin
                n_dq = (b == 8'h22);
                n_mode = stl_pkg::M_STRING;
            end else if (b == "!") begin
                n_mode = stl_pkg::M_BANG;
            end else if (is_dig(b) || is_alp(b) || b == "_" || b == "*" || b == "=" ||
                         b == "(" || b == ")" || b == "," || b == ";" || b == ">" ||
                         b == "<") begin
                bst.recs[bst.count[1:0]] = '{stl_pkg::REC_BYTE, u, 6'd0, 6'd0, 7'd0, 1'b0};
                bst.count = bst.count + 3'd1;
                n_len = LW'(1);
                case (b)
                    "*": fk = stl_pkg::TK_STAR;
                    "=": fk = stl_pkg::TK_EQ;
                    "(": fk = stl_pkg::TK_LPAREN;
                    ")": fk = stl_pkg::TK_RPAREN;
                    ",": fk = stl_pkg::TK_COMMA;
                    ";": fk = stl_pkg::TK_SEMI;
                    default: fk = stl_pkg::TK_IDENT;
                endcase
                if (is_dig(b)) n_mode = stl_pkg::M_NUMBER;
                else if (b == ">") n_mode = stl_pkg::M_GT;
                else if (b == "<") n_mode = stl_pkg::M_LT;
                else if (fk != stl_pkg::TK_IDENT) begin
                    bst.recs[bst.count[1:0]] = '{stl_pkg::REC_TOKEN, 8'd0, fk, 6'd1, 7'd0, 1'b0};
                    bst.count = bst.count + 3'd1;
                    n_tok = n_tok + 1'b1; n_len = '0;
                    n_mode = (n_tok >= TOK_CAP) ? stl_pkg::M_HALT : stl_pkg::M_IDLE;
                end else begin
                    n_mode = stl_pkg::M_IDENT;
                    n_win[63:56] = u;
                end
            end
        end

        // final byte: flush and report
        if (i_last) begin
            fk = stl_pkg::TK_IDENT;
            case (n_mode)
                stl_pkg::M_IDENT: fk = classify(n_win, n_len);
                stl_pkg::M_NUMBER: fk = stl_pkg::TK_NUMBER;
                stl_pkg::M_STRING: fk = stl_pkg::TK_STRING;
                stl_pkg::M_GT: fk = stl_pkg::TK_GT;
                stl_pkg::M_LT: fk = stl_pkg::TK_LT;
                default: fk = stl_pkg::TK_IDENT;
            endcase
            if (n_mode == stl_pkg::M_IDENT || n_mode == stl_pkg::M_NUMBER ||
                n_mode == stl_pkg::M_STRING || n_mode == stl_pkg::M_GT ||
                n_mode == stl_pkg::M_LT) begin
                bst.recs[bst.count[1:0]] = '{stl_pkg::REC_TOKEN, 8'd0, fk, 6'(n_len), 7'd0, 1'b0};
                bst.count = bst.count + 3'd1;
                n_tok = n_tok + 1'b1;
            end
            bst.recs[bst.count[1:0]] = '{stl_pkg::REC_DONE, 8'd0, 6'd0, 6'd0, 7'(n_tok), 1'b0};
            bst.count = bst.count + 3'd1;
            n_mode = stl_pkg::M_IDLE; n_dq = 1'b0; n_len = '0; n_tok = '0;
        end
        if (bst.count != 3'd0) bst.recs[bst.count[1:0] - 2'd1].run_end = 1'b1;
    end

    assign o_burst = bst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= stl_pkg::M_IDLE;
            r_dq <= 1'b0;
            r_len <= '0;
            r_tok <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_dq <= n_dq;
            r_len <= n_len;
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) r_win <= n_win;
    end
endmodule
`default_nettype wire

/* rtl/stl_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stl_back
// record queue: takes a whole burst per push, and while popped and not empty sends one record per cycle
// ----------------------------------------------------------------------------
module stl_back #(
    parameter int DEPTH = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  stl_pkg::t_burst   i_burst,
    output logic              o_room,
    input  wire               i_pop,
    output logic              o_valid,
    output stl_pkg::t_rec     o_rec
);
    localparam int AW = $clog2(DEPTH);

    stl_pkg::t_rec r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt, n_cnt;

    assign o_room = r_cnt <= (AW+1)'(DEPTH - 4);
    assign o_valid = r_cnt != '0;
    assign o_rec = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push) n_cnt = n_cnt + (AW+1)'(i_burst.count);
        if (i_pop && o_valid) n_cnt = n_cnt - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int k = 0; k < 4; k++) begin
                if (k < int'(i_burst.count)) r_mem[AW'(r_wp + AW'(k))] <= i_burst.recs[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + AW'(i_burst.count);
            if (i_pop && o_valid) r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end
endmodule
`default_nettype wire

/* rtl/sql_token_lexer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sql_token_lexer
// byte-serial sql tokenizer with a decoupled record queue
// ----------------------------------------------------------------------------
// queue entry: a byte's records are written into the queue when the byte is taken
// throughput: one byte per cycle while the queue has room for four records;
//   records leave one per cycle while ready; bursts fill the 16-entry queue
// reset: synchronous active low, clears lexer state and queue pointers
module sql_token_lexer #(
    parameter int TOKEN_BYTES = 64,
    parameter int MAX_TOKENS = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    stl_in_if.sink     i_req,
    stl_out_if.source  o_rec
);
    stl_pkg::t_burst w_burst;
    stl_pkg::t_rec   w_rec;
    logic            w_room;
    logic            w_take;

    // front stalls only when the queue may not hold a full burst
    assign i_req.ready = w_room;
    assign w_take = i_req.valid && w_room;

    stl_front #(.TOKEN_BYTES(TOKEN_BYTES), .MAX_TOKENS(MAX_TOKENS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take),
        .i_byte(i_req.in_byte), .i_last(i_req.in_last), .o_burst(w_burst)
    );

    stl_back #(.DEPTH(16)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_take), .i_burst(w_burst),
        .o_room(w_room), .i_pop(o_rec.ready), .o_valid(o_rec.valid), .o_rec(w_rec)
    );

    assign o_rec.rec_kind = w_rec.rec_kind;
    assign o_rec.value_byte = w_rec.value_byte;
    assign o_rec.token_kind = w_rec.token_kind;
    assign o_rec.token_length = w_rec.token_length;
    assign o_rec.token_total = w_rec.token_total;
    assign o_rec.run_end = w_rec.run_end;
endmodule
`default_nettype wire
